### rtl/mqf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_pkg
// shared codes, field widths and control/status bundles of the multi-queue fifo
// ----------------------------------------------------------------------------
package mqf_pkg;

    localparam int OP_W    = 2;
    localparam int QI_W    = 3;
    localparam int ID_W    = 8;
    localparam int ST_W    = 2;
    localparam int CNTO_W  = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // finish codes from controller to datapath
    localparam int FIN_W = 3;
    localparam logic [FIN_W-1:0] FIN_NONE  = 3'd0;
    localparam logic [FIN_W-1:0] FIN_PUSH  = 3'd1;
    localparam logic [FIN_W-1:0] FIN_FULL  = 3'd2;
    localparam logic [FIN_W-1:0] FIN_EMPTY = 3'd3;
    localparam logic [FIN_W-1:0] FIN_NOP   = 3'd4;
    localparam logic [FIN_W-1:0] FIN_SCAN  = 3'd5;

    typedef struct packed {
        logic             load;      // capture command, clear scan state
        logic             rd_issue;  // read next entry of the scan
        logic [FIN_W-1:0] fin;       // close the transaction
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            q_ok;
        logic            empty;
        logic            full;
        logic            last_issue;
    } t_dp_stat;

endpackage : mqf_pkg
`default_nettype wire

### rtl/mqf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_dp
// datapath: command registers, per-queue counts, entry memory and scan pipeline
// ----------------------------------------------------------------------------
module mqf_dp
    import mqf_pkg::*;
#(
    parameter int NUM_QUEUES  = 5,
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [QI_W-1:0]   i_queue_index,
    input  wire logic [ID_W-1:0]   i_task_id,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    output logic                   o_result_valid,
    output logic [ID_W-1:0]        o_popped_id,
    output logic [ST_W-1:0]        o_status,
    output logic [CNTO_W-1:0]      o_count_after
);

    localparam int QIW       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [OP_W-1:0]   r_op;
    logic [QI_W-1:0]   r_q;
    logic [ID_W-1:0]   r_id;
    logic [CW-1:0]     r_counts [NUM_QUEUES];
    logic [PW-1:0]     r_ptr;
    logic              r_rd_valid;
    logic [PW-1:0]     r_rd_pos;
    logic [ID_W-1:0]   r_rdata;
    logic              r_found;
    logic [ID_W-1:0]   r_hit;
    logic [ID_W-1:0]   r_mem [MEM_DEPTH];
    logic              r_res_valid;
    logic [ID_W-1:0]   r_popped;
    logic [ST_W-1:0]   r_status;
    logic [CW-1:0]     r_count;

    logic [QIW-1:0]    q_idx;
    logic              q_ok;
    logic [CW-1:0]     cur_count;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic              we;
    logic              match;
    logic              find;
    logic              shift_we;
    logic              is_push;

    assign q_idx = QIW'(r_q);
    assign q_ok  = (int'(r_q) < NUM_QUEUES);

    always_comb begin
        cur_count = '0;
        if (q_ok) begin
            cur_count = r_counts[q_idx];
        end
    end

    // scan: read entries in order, after the hit move each entry one slot toward the head
    assign match    = (r_op == OP_POP) || (r_rdata == r_id);
    assign find     = r_rd_valid && !r_found && match;
    assign shift_we = r_rd_valid && r_found;
    assign is_push  = (i_cmd.fin == FIN_PUSH);

    assign rd_addr = AW'(int'(q_idx) * QUEUE_DEPTH + int'(r_ptr));

    always_comb begin
        we      = shift_we || is_push;
        wr_addr = AW'(int'(q_idx) * QUEUE_DEPTH + int'(r_rd_pos) - 1);
        wr_data = r_rdata;
        if (is_push) begin
            wr_addr = AW'(int'(q_idx) * QUEUE_DEPTH + int'(cur_count));
            wr_data = r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.q_ok       = q_ok;
        o_stat.empty      = (cur_count == '0);
        o_stat.full       = (cur_count >= CW'(QUEUE_DEPTH));
        o_stat.last_issue = (CW'(r_ptr) == cur_count - CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_q  <= i_queue_index;
            r_id <= i_task_id;
        end
        if (i_cmd.rd_issue) begin
            r_rd_pos <= r_ptr;
        end
        if (find) begin
            r_hit <= (r_op == OP_POP) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_rd_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_rd_valid  <= i_cmd.rd_issue;
            r_res_valid <= (i_cmd.fin != FIN_NONE);
            if (i_cmd.load) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.rd_issue) begin
                    r_ptr <= r_ptr + PW'(1);
                end
                if (find) begin
                    r_found <= 1'b1;
                end
            end
            if (is_push) begin
                r_counts[q_idx] <= cur_count + CW'(1);
            end else if ((i_cmd.fin == FIN_SCAN) && r_found) begin
                r_counts[q_idx] <= cur_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.fin)
            FIN_PUSH: begin
                r_popped <= '0;
                r_status <= ST_OK;
                r_count  <= cur_count + CW'(1);
            end
            FIN_FULL: begin
                r_popped <= '0;
                r_status <= ST_FULL;
                r_count  <= cur_count;
            end
            FIN_EMPTY: begin
                r_popped <= '0;
                r_status <= ST_EMPTY;
                r_count  <= cur_count;
            end
            FIN_NOP: begin
                r_popped <= '0;
                r_status <= ST_OK;
                r_count  <= cur_count;
            end
            FIN_SCAN: begin
                if (r_found) begin
                    r_popped <= r_hit;
                    r_status <= ST_OK;
                    r_count  <= cur_count - CW'(1);
                end else begin
                    r_popped <= '0;
                    r_status <= ST_NOTFOUND;
                    r_count  <= cur_count;
                end
            end
            default: begin
                r_popped <= r_popped;
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_popped_id    = r_popped;
    assign o_status       = r_status;
    assign o_count_after  = CNTO_W'(r_count);

endmodule : mqf_dp
`default_nettype wire

### rtl/mqf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqf_ctrl
// controller: decodes the command and sequences the entry scan
// ----------------------------------------------------------------------------
module mqf_ctrl
    import mqf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.fin      = FIN_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                case (i_stat.op)
                    OP_PUSH: begin
                        o_cmd.fin = (!i_stat.q_ok || i_stat.full) ? FIN_FULL : FIN_PUSH;
                    end
                    OP_POP, OP_REMOVE: begin
                        if (!i_stat.q_ok || i_stat.empty) begin
                            o_cmd.fin = FIN_EMPTY;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.fin = FIN_NOP;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_stat.last_issue) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = FIN_SCAN;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule : mqf_ctrl
`default_nettype wire

### rtl/multi_queue_fifo_with_removal_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_fifo_with_removal_top
// several fifo queues of task ids with push, pop and remove-by-id
// ----------------------------------------------------------------------------
// a command is taken when start is high and busy is low. every command gives
// exactly one result, shown for one cycle with o_result_valid high; the
// receiver cannot stall, so it must take the result in that cycle. push,
// no-op and any command that fails on an empty, full or out-of-range queue
// are closed in the check state; the result shows in the cycle after that.
// pop and remove on a non-empty queue walk the queue's entries through the
// entry memory (one read port and one write port), one entry per cycle,
// reading each entry and writing it back one slot toward the head once the
// hit has been passed; busy stays high through the check, scan, wait and
// finish states. pop and remove always walk the whole queue. failed
// commands leave the state as it was. the entry memory needs no clearing
// after reset: only the per-queue counts are reset, and only entries below
// a count are read.
// ----------------------------------------------------------------------------
module multi_queue_fifo_with_removal_top
    import mqf_pkg::*;
#(
    parameter int NUM_QUEUES  = 5,
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [QI_W-1:0]   i_queue_index,
    input  wire logic [ID_W-1:0]   i_task_id,
    output logic                   o_result_valid,
    output logic [ID_W-1:0]        o_popped_id,
    output logic [ST_W-1:0]        o_status,
    output logic [CNTO_W-1:0]      o_count_after
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing of each transaction
    mqf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // counts, entry memory and result registers
    mqf_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_op),
        .i_queue_index  (i_queue_index),
        .i_task_id      (i_task_id),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result_valid (o_result_valid),
        .o_popped_id    (o_popped_id),
        .o_status       (o_status),
        .o_count_after  (o_count_after)
    );

`ifndef SYNTHESIS
    // a result strobe lasts exactly one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // when a result shows, the block is already free for the next transaction
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while still busy");

    // a failing transaction never returns an id
    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_OK)) |-> (o_popped_id == '0))
        else $error("id returned with a failure status");
`endif

endmodule : multi_queue_fifo_with_removal_top
`default_nettype wire

### tb/sv/tb_multi_queue_fifo_with_removal_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_multi_queue_fifo_with_removal_top
// self-checking bench for the multi-queue task id fifo with remove-by-id
// ----------------------------------------------------------------------------
// commands are driven on the falling edge and taken on start && !busy. a
// shadow copy of every queue predicts each command's result at acceptance;
// results are checked field by field, in order, as the strobe shows them.
// a short directed list covers empty, full, out-of-range, no-op, duplicate
// and not-found cases, then 480 random commands follow,
// with two fill-to-full bursts, one full drain and random sender gaps.
// ----------------------------------------------------------------------------
module tb_multi_queue_fifo_with_removal_top;
    import mqf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_Q      = 5;
    localparam int DEPTH      = 64;
    localparam int QUIET_MAX  = 3000;   // idle cycles before the watchdog trips
    localparam int TAIL_WAIT  = 70;     // longest walk of a full queue plus margin
    localparam int RAND_ITEMS = 480;

    // one result of the block
    typedef struct packed {
        logic [ID_W-1:0]   popped;
        logic [ST_W-1:0]   status;
        logic [CNTO_W-1:0] count;
    } t_result;

    // one directed command, with a hand-written result where it is obvious
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [QI_W-1:0] qi;
        logic [ID_W-1:0] id;
        logic            typed;
        t_result         want;
    } t_row;

    localparam int N_ROWS = 24;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // everything empty straight after reset
        '{OP_POP,    3'd0, 8'h00, 1'b1, '{8'h00, ST_EMPTY, 7'd0}},
        '{OP_REMOVE, 3'd0, 8'h33, 1'b1, '{8'h00, ST_EMPTY, 7'd0}},
        // queue index past the last queue acts as a zero-capacity queue
        '{OP_PUSH,   3'd5, 8'h11, 1'b1, '{8'h00, ST_FULL,  7'd0}},
        '{OP_POP,    3'd7, 8'h00, 1'b1, '{8'h00, ST_EMPTY, 7'd0}},
        '{OP_REMOVE, 3'd6, 8'hFF, 1'b1, '{8'h00, ST_EMPTY, 7'd0}},
        // the unused op code does nothing
        '{OP_NOP,    3'd7, 8'hFF, 1'b1, '{8'h00, ST_OK,    7'd0}},
        '{OP_NOP,    3'd2, 8'h00, 1'b1, '{8'h00, ST_OK,    7'd0}},
        // single push and pop round trip with the largest id
        '{OP_PUSH,   3'd0, 8'hFF, 1'b1, '{8'h00, ST_OK,    7'd1}},
        '{OP_POP,    3'd0, 8'h00, 1'b1, '{8'hFF, ST_OK,    7'd0}},
        // last queue: duplicates, removal at head, middle and tail
        '{OP_PUSH,   3'd4, 8'h00, 1'b1, '{8'h00, ST_OK,    7'd1}},
        '{OP_PUSH,   3'd4, 8'hAA, 1'b0, '0},
        '{OP_PUSH,   3'd4, 8'h55, 1'b0, '0},
        '{OP_PUSH,   3'd4, 8'hAA, 1'b0, '0},
        '{OP_PUSH,   3'd4, 8'hFF, 1'b0, '0},
        '{OP_REMOVE, 3'd4, 8'hAA, 1'b0, '0},
        '{OP_REMOVE, 3'd4, 8'h12, 1'b0, '0},
        '{OP_REMOVE, 3'd4, 8'hFF, 1'b0, '0},
        '{OP_POP,    3'd4, 8'h00, 1'b0, '0},
        '{OP_NOP,    3'd4, 8'h00, 1'b0, '0},
        '{OP_REMOVE, 3'd4, 8'h55, 1'b0, '0},
        '{OP_POP,    3'd4, 8'h00, 1'b0, '0},
        '{OP_POP,    3'd4, 8'h00, 1'b0, '0},
        // single-entry queue removed by id
        '{OP_PUSH,   3'd1, 8'h80, 1'b0, '0},
        '{OP_REMOVE, 3'd1, 8'h80, 1'b0, '0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_op;
    logic [QI_W-1:0]   i_queue_index;
    logic [ID_W-1:0]   i_task_id;
    logic              o_result_valid;
    logic [ID_W-1:0]   o_popped_id;
    logic [ST_W-1:0]   o_status;
    logic [CNTO_W-1:0] o_count_after;

    // shadow copy of the queues, updated when a command is accepted
    logic [ID_W-1:0] shadow_ids [NUM_Q][DEPTH];
    int              shadow_count [NUM_Q];

    t_result pending_results[$];   // predicted results not yet seen

    int mismatch_count;
    int commands_sent;
    int results_checked;
    int status_seen [4];
    int peak_count;
    int quiet_cycles;

    multi_queue_fifo_with_removal_top #(
        .NUM_QUEUES  (NUM_Q),
        .QUEUE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_queue_index  (i_queue_index),
        .i_task_id      (i_task_id),
        .o_result_valid (o_result_valid),
        .o_popped_id    (o_popped_id),
        .o_status       (o_status),
        .o_count_after  (o_count_after)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one line per mismatch, and a tally for the final verdict
    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // delete slot pos of queue q, sliding later entries toward the head
    function automatic void drop_entry(input int q, input int pos);
        for (int i = pos; i + 1 < shadow_count[q]; i++)
            shadow_ids[q][i] = shadow_ids[q][i + 1];
        shadow_count[q]--;
    endfunction

    // result of one command on the shadow queues; updates them on success
    function automatic t_result predict_command(input logic [OP_W-1:0] op,
                                                input logic [QI_W-1:0] qi,
                                                input logic [ID_W-1:0] id);
        t_result r;
        int      q;
        int      hit;
        r   = '0;
        q   = int'(qi);
        hit = -1;
        r.status = ST_OK;
        if (q >= NUM_Q) begin
            // out-of-range queue: no capacity, never any entries
            if (op == OP_PUSH)
                r.status = ST_FULL;
            else if (op == OP_POP || op == OP_REMOVE)
                r.status = ST_EMPTY;
        end else begin
            case (op)
                OP_PUSH: begin
                    if (shadow_count[q] >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        shadow_ids[q][shadow_count[q]] = id;
                        shadow_count[q]++;
                    end
                end
                OP_POP: begin
                    if (shadow_count[q] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = shadow_ids[q][0];
                        drop_entry(q, 0);
                    end
                end
                OP_REMOVE: begin
                    if (shadow_count[q] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // only the match nearest the head goes
                        for (int i = 0; i < shadow_count[q]; i++)
                            if (hit < 0 && shadow_ids[q][i] == id)
                                hit = i;
                        if (hit >= 0)
                            drop_entry(q, hit);
                        else
                            r.status = ST_NOTFOUND;
                    end
                end
                default: ;
            endcase
            r.count = CNTO_W'(shadow_count[q]);
            if (shadow_count[q] > peak_count)
                peak_count = shadow_count[q];
        end
        return r;
    endfunction

    // drive one command and hold it until the block takes it; the expected
    // result is worked out at the accepting edge
    task automatic send_command(input logic [OP_W-1:0] op, input logic [QI_W-1:0] qi,
                                input logic [ID_W-1:0] id, input logic typed,
                                input t_result typed_want);
        t_result predicted;
        @(negedge i_clk);
        start         = 1'b1;
        i_op          = op;
        i_queue_index = qi;
        i_task_id     = id;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predicted = predict_command(op, qi, id);
        pending_results.push_back(typed ? typed_want : predicted);
        commands_sent++;
    endtask

    // mostly back to back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic idle_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // any id, with a bias toward a handful of values so duplicates happen
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) == 0)
            return ID_W'($urandom_range(0, 7));
        return ID_W'($urandom_range(0, 255));
    endfunction

    // push until the queue is full, then twice more to hit the full status,
    // then take out an entry from the middle of the full queue and pop the head
    task automatic fill_queue(input int q);
        wait_drained();
        while (shadow_count[q] < DEPTH) begin
            idle_gap(pick_gap());
            send_command(OP_PUSH, QI_W'(q), pick_id(), 1'b0, '0);
        end
        repeat (2)
            send_command(OP_PUSH, QI_W'(q), pick_id(), 1'b0, '0);
        send_command(OP_REMOVE, QI_W'(q), shadow_ids[q][DEPTH / 2], 1'b0, '0);
        send_command(OP_POP, QI_W'(q), 8'h00, 1'b0, '0);
    endtask

    // result checker: the receiver cannot stall, so every strobe is a transaction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                want = pending_results.pop_front();
                if (o_popped_id !== want.popped)
                    report_mismatch("popped_id", want.popped, o_popped_id);
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_count_after !== want.count)
                    report_mismatch("count_after", want.count, o_count_after);
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // watchdog: trips after a long stretch with no accepted command and no result
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("%0t watchdog: no progress for %0d cycles", $realtime, QUIET_MAX);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int                roll;
        int                q;
        int                n_left;
        int                drain_q;
        logic [ID_W-1:0]   tid;
        // known values on every input from time zero
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_op            = OP_NOP;
        i_queue_index   = '0;
        i_task_id       = '0;
        mismatch_count  = 0;
        commands_sent   = 0;
        results_checked = 0;
        peak_count      = 0;
        quiet_cycles    = 0;
        status_seen     = '{default: 0};
        shadow_count    = '{default: 0};

        // synchronous reset held low, released on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed list
        for (int r = 0; r < N_ROWS; r++) begin
            idle_gap(pick_gap());
            send_command(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].qi, DIRECTED_ROWS[r].id,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        wait_drained();

        // random commands, with fill bursts and one full drain along the way
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 120)
                fill_queue($urandom_range(0, NUM_Q - 1));
            if (n == 330) begin
                drain_q = $urandom_range(0, NUM_Q - 1);
                fill_queue(drain_q);
                // empty it again by pops and removes of entries that are present
                while (shadow_count[drain_q] > 0) begin
                    idle_gap(pick_gap());
                    if ($urandom_range(0, 1) == 0) begin
                        send_command(OP_POP, QI_W'(drain_q), pick_id(), 1'b0, '0);
                    end else begin
                        tid = shadow_ids[drain_q][$urandom_range(0, shadow_count[drain_q] - 1)];
                        send_command(OP_REMOVE, QI_W'(drain_q), tid, 1'b0, '0);
                    end
                end
            end

            // a stretch of back-to-back commands with no sender gaps
            if (n < 200 || n >= 280)
                idle_gap(pick_gap());

            roll = $urandom_range(0, 99);
            q    = $urandom_range(0, NUM_Q - 1);
            if (roll < 45) begin
                send_command(OP_PUSH, QI_W'(q), pick_id(), 1'b0, '0);
            end else if (roll < 65) begin
                send_command(OP_POP, QI_W'(q), ID_W'($urandom_range(0, 255)), 1'b0, '0);
            end else if (roll < 85) begin
                // remove mostly something that is there, sometimes a random id
                n_left = shadow_count[q];
                if (n_left > 0 && $urandom_range(0, 3) != 0)
                    tid = shadow_ids[q][$urandom_range(0, n_left - 1)];
                else
                    tid = ID_W'($urandom_range(0, 255));
                send_command(OP_REMOVE, QI_W'(q), tid, 1'b0, '0);
            end else if (roll < 93) begin
                // queue index past the end, any op code
                send_command(OP_W'($urandom_range(0, 3)), QI_W'($urandom_range(NUM_Q, 7)),
                             ID_W'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
                send_command(OP_NOP, QI_W'(q), ID_W'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        // let the last results arrive, then watch a little longer for strays
        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("run: %0d commands sent, %0d results checked, deepest queue %0d of %0d",
                 commands_sent, results_checked, peak_count, DEPTH);
        $display("statuses seen: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND], mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : tb_multi_queue_fifo_with_removal_top
`default_nettype wire

### files.f
rtl/mqf_pkg.sv
rtl/mqf_dp.sv
rtl/mqf_ctrl.sv
rtl/multi_queue_fifo_with_removal_top.sv
tb/sv/tb_multi_queue_fifo_with_removal_top.sv
